// ----- rtl/afrc_pkg.sv -----
// ----------------------------------------------------------------------------
// afrc_pkg
// Shared types and constants of the wideband O2 AFR conditioner.
// ----------------------------------------------------------------------------
package afrc_pkg;

  localparam int SAMPLES_PER_READING = 16;   // power of two: average is a shift
  localparam int ADC_BITS            = 12;

  localparam int AVG_SHIFT = $clog2(SAMPLES_PER_READING);
  localparam int SUM_W     = ADC_BITS + AVG_SHIFT;
  localparam int CNT_W     = $clog2(SAMPLES_PER_READING + 1);

  localparam int GAIN_W   = 24;
  localparam int CVG_W    = 16;
  localparam int AFR_W    = 16;
  localparam int ALPHA_W  = 9;
  localparam int CV_W     = 8;
  localparam int EMA_W    = AFR_W + 8;           // AFR x100 in Q8
  localparam int PROD_W   = ADC_BITS + GAIN_W;   // shared map / centivolt product
  localparam int EPROD_W  = ALPHA_W + EMA_W;     // EMA partial products

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_OFFSET  = 3'd0,
    CFG_MAP_GAIN    = 3'd1,
    CFG_MIN_AFR     = 3'd2,
    CFG_MAX_AFR     = 3'd3,
    CFG_FAULT_LOW   = 3'd4,
    CFG_FAULT_HIGH  = 3'd5,
    CFG_EMA_ALPHA   = 3'd6,
    CFG_CV_GAIN     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] map_offset_code;
    logic [GAIN_W-1:0]   map_gain;
    logic [AFR_W-1:0]    min_afr_centi;
    logic [AFR_W-1:0]    max_afr_centi;
    logic [ADC_BITS-1:0] fault_low_code;
    logic [ADC_BITS-1:0] fault_high_code;
    logic [ALPHA_W-1:0]  ema_alpha;
    logic [CVG_W-1:0]    centivolt_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_MAP,
    ST_EMA_A,
    ST_EMA_B,
    ST_EMA_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accum;
    logic check;
    logic mul;
    logic map;
    logic ema_a;
    logic ema_b;
    logic ema_sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_sample;
    logic fault_now;
    logic flt;
    logic in_fault;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/wideband_o2_afr_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// wideband_o2_afr_conditioner_top
// Oversampled ADC to AFR x100 conditioner with fault events and EMA smoothing.
// ----------------------------------------------------------------------------
// Mid-group samples are accepted one per cycle and give no item.
// The last sample of a group starts a sequence of one step per cycle, stalled only in the
// emit step while the output is full; a fault raise skips the map and EMA steps.
// Sample input is held off during that sequence and while the result waits.
// Synchronous reset clears the accumulator, fault and EMA state and loads
// register defaults; no clearing pass is needed.
module wideband_o2_afr_conditioner_top import afrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] adc_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] afr_centi, [23:16] fault_centivolts
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] data_valid, [1] fault_raised,
                                                // [2] fault_cleared
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  afrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  afrc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  afrc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .st            (st),
    .sample        (s_axis_tdata[ADC_BITS-1:0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/afrc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// afrc_cfg_regs
// Configuration register file written through the index/data channel.
// ----------------------------------------------------------------------------
module afrc_cfg_regs import afrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_idx_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_offset_code <= '0;
      cfg.map_gain        <= GAIN_W'(21128);
      cfg.min_afr_centi   <= AFR_W'(1000);
      cfg.max_afr_centi   <= AFR_W'(2000);
      cfg.fault_low_code  <= ADC_BITS'(25);
      cfg.fault_high_code <= ADC_BITS'(4032);
      cfg.ema_alpha       <= ALPHA_ONE;
      cfg.centivolt_gain  <= CVG_W'(5281);
    end else if (cfg_valid) begin
      unique case (idx)
        CFG_MAP_OFFSET: cfg.map_offset_code <= cfg_data[ADC_BITS-1:0];
        CFG_MAP_GAIN:   cfg.map_gain        <= cfg_data[GAIN_W-1:0];
        CFG_MIN_AFR:    cfg.min_afr_centi   <= cfg_data[AFR_W-1:0];
        CFG_MAX_AFR:    cfg.max_afr_centi   <= cfg_data[AFR_W-1:0];
        CFG_FAULT_LOW:  cfg.fault_low_code  <= cfg_data[ADC_BITS-1:0];
        CFG_FAULT_HIGH: cfg.fault_high_code <= cfg_data[ADC_BITS-1:0];
        CFG_EMA_ALPHA:  cfg.ema_alpha       <= cfg_data[ALPHA_W-1:0];
        CFG_CV_GAIN:    cfg.centivolt_gain  <= cfg_data[CVG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/afrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// afrc_ctrl
// Sequencer: accepts samples and steps the datapath through a group end.
// ----------------------------------------------------------------------------
module afrc_ctrl import afrc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.accum = 1'b1;
          if (st.last_sample) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        // stay silent while the fault persists
        if (st.fault_now && st.in_fault) state_next = ST_IDLE;
        else                             state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = st.flt ? ST_EMIT : ST_MAP;
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_EMA_A;
      end
      ST_EMA_A: begin
        cmd.ema_a  = 1'b1;
        state_next = ST_EMA_B;
      end
      ST_EMA_B: begin
        cmd.ema_b  = 1'b1;
        state_next = ST_EMA_SUM;
      end
      ST_EMA_SUM: begin
        cmd.ema_sum = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/afrc_dp.sv -----
// ----------------------------------------------------------------------------
// afrc_dp
// Datapath: sample accumulator, fault check, linear map, EMA, output register.
// ----------------------------------------------------------------------------
module afrc_dp import afrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [ADC_BITS-1:0]   sample,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic [CNT_W-1:0]    cnt;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_new;
  logic [ADC_BITS-1:0] avg;
  logic                flt;
  logic                in_fault;
  logic                fault_now;
  logic [PROD_W-1:0]   prod;
  logic [EMA_W-1:0]    x;
  logic [EPROD_W-1:0]  p1, p2;
  logic [EMA_W-1:0]    ema;
  logic                seeded;

  logic [EMA_W-1:0]    lo, hi;
  logic [PROD_W-8:0]   mapped;
  logic [ALPHA_W-1:0]  alpha, alpha_inv;
  logic [EMA_W-1:0]    ema_eff;
  logic [EPROD_W:0]    ema_acc;
  logic [EMA_W:0]      afr_rnd;
  logic [AFR_W-1:0]    afr;
  logic [CV_W-1:0]     cv;

  assign sum_new   = sum + SUM_W'(sample);
  assign fault_now = (avg < cfg.fault_low_code) || (avg > cfg.fault_high_code);

  assign lo     = {cfg.min_afr_centi, 8'd0};
  assign hi     = {cfg.max_afr_centi, 8'd0};
  // mapped never falls below lo; a max below min still clamps to max
  assign mapped = (PROD_W-7)'(lo) + (PROD_W-7)'(prod[PROD_W-1:8]);

  assign alpha     = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;
  assign alpha_inv = ALPHA_ONE - alpha;
  assign ema_eff   = seeded ? ema : x;
  assign ema_acc   = (EPROD_W+1)'(p1) + (EPROD_W+1)'(p2) + (EPROD_W+1)'(128);

  assign afr_rnd = (EMA_W+1)'(ema) + (EMA_W+1)'(128);
  assign afr     = afr_rnd[EMA_W] ? '1 : afr_rnd[EMA_W-1:8];
  assign cv      = (|prod[PROD_W-1:16+CV_W]) ? '1 : prod[16+CV_W-1:16];

  assign st.last_sample = (cnt == CNT_W'(SAMPLES_PER_READING - 1));
  assign st.fault_now   = fault_now;
  assign st.flt         = flt;
  assign st.in_fault    = in_fault;
  assign st.out_free    = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sum <= '0;
    end else if (cmd.accum) begin
      if (st.last_sample) begin
        cnt <= '0;
        sum <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
        sum <= sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && st.last_sample) avg <= sum_new[SUM_W-1:AVG_SHIFT];
    if (cmd.check) flt <= fault_now;
    if (cmd.mul) begin
      if (flt)
        prod <= PROD_W'(avg * cfg.centivolt_gain);
      else if (avg > cfg.map_offset_code)
        prod <= PROD_W'((avg - cfg.map_offset_code) * cfg.map_gain);
      else
        prod <= '0;
    end
    if (cmd.map)   x  <= (mapped > (PROD_W-7)'(hi)) ? hi : mapped[EMA_W-1:0];
    if (cmd.ema_a) p1 <= EPROD_W'(alpha * x);
    if (cmd.ema_b) p2 <= EPROD_W'(alpha_inv * ema_eff);
    if (cmd.ema_sum) ema <= ema_acc[EMA_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
    end else if (cmd.ema_sum) begin
      seeded <= 1'b1;
    end
  end

  // output register; tuser = {fault_cleared, fault_raised, data_valid}
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      in_fault      <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
      if (flt) begin
        m_axis_tdata <= {cv, AFR_W'(0)};
        m_axis_tuser <= 3'b010;
        in_fault     <= 1'b1;
      end else begin
        m_axis_tdata <= {CV_W'(0), afr};
        m_axis_tuser <= {in_fault, 2'b01};
        in_fault     <= 1'b0;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("reading and fault raise in one item");

  a_clear_with_reading: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0])
    else $error("fault clear without a reading");

  a_raise_zero_afr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[AFR_W-1:0] == '0)
    else $error("fault raise carries an AFR value");

  a_fault_track: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> in_fault == $past(flt))
    else $error("fault state does not follow the emitted item");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wideband O2 AFR conditioner. Drives ADC sample
// groups through the stream input under random idling on both sides, rewrites
// the eight registers between phases, and compares each output item with a
// cycle-free model of the averaging, fault events, AFR map and EMA.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afrc_pkg::*;

  typedef struct packed {
    logic [AFR_W-1:0] afr_centi;
    logic             data_valid;
    logic             fault_raised;
    logic             fault_cleared;
    logic [CV_W-1:0]  fault_centivolts;
  } report_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wideband_o2_afr_conditioner_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // conditioner model state
  cfg_t            regs;
  int unsigned     group_fill;
  logic [19:0]     group_sum;
  bit              in_fault;
  logic [EMA_W-1:0] ema_acc;
  bit              ema_primed;

  report_t pending_reports[$];
  int      fail_count;
  bit      steady;          // no random idling on either side while set
  int      hold_request;    // receiver hold-off length, picked up by the receiver

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cfg_t default_regs();
    cfg_t c;
    c.map_offset_code = '0;
    c.map_gain        = GAIN_W'(21128);
    c.min_afr_centi   = AFR_W'(1000);
    c.max_afr_centi   = AFR_W'(2000);
    c.fault_low_code  = ADC_BITS'(25);
    c.fault_high_code = ADC_BITS'(4032);
    c.ema_alpha       = ALPHA_ONE;
    c.centivolt_gain  = CVG_W'(5281);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(input string what, input report_t want, input report_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t mismatch (%s): exp afr=%0d dv=%0b raise=%0b clear=%0b cv=%0d",
                " | got afr=%0d dv=%0b raise=%0b clear=%0b cv=%0d"},
               $realtime, what, want.afr_centi, want.data_valid, want.fault_raised,
               want.fault_cleared, want.fault_centivolts, got.afr_centi, got.data_valid,
               got.fault_raised, got.fault_cleared, got.fault_centivolts);
  endtask

  // Advance the model by one accepted sample; queue the report a group end causes.
  task automatic condition_sample(input logic [ADC_BITS-1:0] code);
    logic [19:0]      avg_code;
    logic [47:0]      lo, hi, mapped, blend, rounded, cv;
    logic [ALPHA_W-1:0] a;
    report_t          r;
    group_sum  = group_sum + 20'(code);
    group_fill = group_fill + 1;
    if (group_fill < SAMPLES_PER_READING) return;
    avg_code   = 20'(group_sum / SAMPLES_PER_READING);
    group_sum  = '0;
    group_fill = 0;
    r = '0;
    if (avg_code < regs.fault_low_code || avg_code > regs.fault_high_code) begin
      if (in_fault) return;
      in_fault = 1'b1;
      cv = (48'(avg_code) * 48'(regs.centivolt_gain)) >> 16;
      r.fault_raised     = 1'b1;
      r.fault_centivolts = (cv > 48'd255) ? 8'hFF : cv[7:0];
      pending_reports.push_back(r);
      return;
    end
    if (in_fault) begin
      in_fault = 1'b0;
      r.fault_cleared = 1'b1;
    end
    lo = 48'(regs.min_afr_centi) << 8;
    hi = 48'(regs.max_afr_centi) << 8;
    mapped = lo;
    if (avg_code > regs.map_offset_code)
      mapped = lo + ((48'(avg_code - regs.map_offset_code) * 48'(regs.map_gain)) >> 8);
    if (mapped < lo) mapped = lo;
    if (mapped > hi) mapped = hi;
    if (!ema_primed) begin
      ema_acc    = mapped[EMA_W-1:0];
      ema_primed = 1'b1;
    end
    a = (regs.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : regs.ema_alpha;
    blend = (48'(a) * mapped + 48'(ALPHA_ONE - a) * 48'(ema_acc) + 48'd128) >> 8;
    ema_acc = blend[EMA_W-1:0];
    rounded = (48'(ema_acc) + 48'd128) >> 8;
    r.afr_centi  = (rounded > 48'hFFFF) ? 16'hFFFF : rounded[AFR_W-1:0];
    r.data_valid = 1'b1;
    pending_reports.push_back(r);
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(code);
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    condition_sample(code);
  endtask

  task automatic send_level(input logic [ADC_BITS-1:0] code);
    repeat (SAMPLES_PER_READING) send_sample(code);
  endtask

  // alternate two codes; the average is their truncated mean
  task automatic send_pair(input logic [ADC_BITS-1:0] a, input logic [ADC_BITS-1:0] b);
    repeat (SAMPLES_PER_READING / 2) begin
      send_sample(a);
      send_sample(b);
    end
  endtask

  task automatic send_noisy(input int base, input int spread);
    int v;
    repeat (SAMPLES_PER_READING) begin
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(ADC_BITS'(v));
    end
  endtask

  // Drop the input, wait out every report, then the sequence of a silent group end.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(input cfg_t c, input cfg_idx_t idx);
    case (idx)
      CFG_MAP_OFFSET: return CFG_DATA_W'(c.map_offset_code);
      CFG_MAP_GAIN:   return CFG_DATA_W'(c.map_gain);
      CFG_MIN_AFR:    return CFG_DATA_W'(c.min_afr_centi);
      CFG_MAX_AFR:    return CFG_DATA_W'(c.max_afr_centi);
      CFG_FAULT_LOW:  return CFG_DATA_W'(c.fault_low_code);
      CFG_FAULT_HIGH: return CFG_DATA_W'(c.fault_high_code);
      CFG_EMA_ALPHA:  return CFG_DATA_W'(c.ema_alpha);
      default:        return CFG_DATA_W'(c.centivolt_gain);
    endcase
  endfunction

  // Write all eight registers; only called with the block idle.
  task automatic load_regs(input cfg_t c);
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_value(c, idx);
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  // Output side: check each item, then pick the next ready level.
  initial begin : receiver
    report_t got, want;
    int hold_left, stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.afr_centi        = m_axis_tdata[15:0];
        got.fault_centivolts = m_axis_tdata[23:16];
        got.data_valid       = m_axis_tuser[0];
        got.fault_raised     = m_axis_tuser[1];
        got.fault_cleared    = m_axis_tuser[2];
        if (pending_reports.size() == 0) begin
          note_failure("no item expected", '0, got);
        end else begin
          want = pending_reports.pop_front();
          if (got.afr_centi !== want.afr_centi || got.data_valid !== want.data_valid ||
              got.fault_raised !== want.fault_raised ||
              got.fault_cleared !== want.fault_cleared ||
              got.fault_centivolts !== want.fault_centivolts)
            note_failure("field", want, got);
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 50);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_fault_events();
    send_level(12'd2048);                 // first reading seeds the EMA
    send_level(12'd0);                    // disconnected: raise, zero volts
    send_level(12'd0);                    // still faulted: silent
    send_level(12'hFFF);                  // fault changes kind: still silent
    send_pair(12'hAAA, 12'h555);          // recovery: clear rides on the reading
    send_level(12'hFFF);                  // shorted: voltage saturates
    send_pair(12'h000, 12'hFFF);          // recovery
    for (int k = 0; k < SAMPLES_PER_READING; k++) send_sample(ADC_BITS'(k));  // truncated average
    send_level(12'd3333);
    settle();
  endtask

  task automatic test_thresholds();
    cfg_t c;
    c = default_regs();
    c.fault_low_code  = 12'd100;
    c.fault_high_code = 12'd3000;
    load_regs(c);
    send_level(12'd100);
    send_level(12'd99);
    send_level(12'd3000);
    send_level(12'd3001);
    send_level(12'd3000);
    settle();
    // no fault window at all
    c.fault_low_code  = 12'd0;
    c.fault_high_code = 12'hFFF;
    load_regs(c);
    send_level(12'd0);
    send_level(12'hFFF);
    settle();
    // inverted window: every group is a fault; sweep the voltage scale
    c.fault_low_code  = 12'hFFF;
    c.fault_high_code = 12'd0;
    c.centivolt_gain  = 16'hFFFF;
    load_regs(c);
    send_level(12'd200);
    send_level(12'd2048);
    settle();
    c.fault_low_code  = 12'd0;
    c.fault_high_code = 12'hFFF;
    load_regs(c);
    send_level(12'd1);
    settle();
    c.fault_low_code  = 12'hFFF;
    c.fault_high_code = 12'd0;
    load_regs(c);
    send_level(12'd300);
    settle();
    c.fault_low_code  = 12'd0;
    c.fault_high_code = 12'hFFF;
    c.centivolt_gain  = 16'd0;
    load_regs(c);
    send_level(12'd2000);
    settle();
    c.fault_low_code  = 12'hFFF;
    c.fault_high_code = 12'd0;
    load_regs(c);
    send_level(12'hFFF);
    settle();
    load_regs(default_regs());
    send_level(12'd1500);
    settle();
  endtask

  task automatic test_map_extremes();
    cfg_t c;
    c = default_regs();
    c.map_offset_code = 12'hFFF;          // every average at or below the offset
    load_regs(c);
    send_level(12'd3000);
    settle();
    c.map_offset_code = 12'd0;
    c.map_gain        = 24'hFFFFFF;
    c.min_afr_centi   = 16'd0;
    c.max_afr_centi   = 16'hFFFF;
    c.fault_low_code  = 12'd0;
    c.fault_high_code = 12'hFFF;
    load_regs(c);
    send_level(12'hFFF);
    send_level(12'd1);
    send_level(12'd0);
    settle();
    c.min_afr_centi = 16'd3000;           // max below min: max wins
    c.max_afr_centi = 16'd1000;
    load_regs(c);
    send_level(12'd2000);
    settle();
    c.min_afr_centi = 16'hFFFF;
    c.max_afr_centi = 16'hFFFF;
    c.map_gain      = 24'd0;
    load_regs(c);
    send_level(12'd10);
    settle();
    c.min_afr_centi = 16'd0;
    c.max_afr_centi = 16'd0;
    load_regs(c);
    send_level(12'd4000);
    settle();
  endtask

  task automatic test_smoothing();
    cfg_t c;
    logic [ALPHA_W-1:0] alphas[6];
    alphas = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd300, 9'h1FF};
    c = default_regs();
    foreach (alphas[k]) begin
      c.ema_alpha = alphas[k];
      load_regs(c);
      send_level(12'd500);
      send_level(12'd3500);
      settle();
    end
  endtask

  // Hold the output off while the sender keeps pushing so the input stalls.
  task automatic test_backpressure();
    steady       = 1'b1;
    hold_request = 400;
    load_regs(default_regs());
    send_level(12'd1200);
    send_level(12'd10);
    send_level(12'd2600);
    send_noisy(1800, 300);
    settle();
    steady = 1'b0;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.map_offset_code = ($urandom_range(0, 4) == 0) ? ADC_BITS'($urandom_range(0, 1) * 4095)
                                                    : ADC_BITS'($urandom_range(0, 600));
    c.map_gain        = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom())
                                                    : GAIN_W'($urandom_range(0, 131072));
    c.min_afr_centi   = ($urandom_range(0, 5) == 0) ? AFR_W'($urandom())
                                                    : AFR_W'($urandom_range(500, 1500));
    c.max_afr_centi   = ($urandom_range(0, 5) == 0) ? AFR_W'($urandom())
                                                    : AFR_W'($urandom_range(1500, 3000));
    c.fault_low_code  = ($urandom_range(0, 5) == 0) ? ADC_BITS'($urandom())
                                                    : ADC_BITS'($urandom_range(0, 200));
    c.fault_high_code = ($urandom_range(0, 5) == 0) ? ADC_BITS'($urandom())
                                                    : ADC_BITS'($urandom_range(3800, 4095));
    c.ema_alpha       = ALPHA_W'($urandom_range(0, 511));
    c.centivolt_gain  = CVG_W'($urandom());
    return c;
  endfunction

  task automatic test_random_settings();
    cfg_t c;
    int   mode, lo, hi;
    for (int phase = 0; phase < 8; phase++) begin
      c = random_regs();
      load_regs(c);
      steady = ($urandom_range(0, 3) == 0);
      lo = int'(c.fault_low_code);
      hi = int'(c.fault_high_code);
      repeat (6) begin
        mode = $urandom_range(0, 99);
        if (mode < 70 && lo <= hi) begin
          send_noisy(int'($urandom_range(lo, hi)), int'($urandom_range(0, 40)));
        end else if (mode < 85) begin
          if ($urandom_range(0, 1) == 0 && lo > 0)
            send_noisy(int'($urandom_range(0, lo - 1)), 0);
          else if (hi < 4095)
            send_noisy(int'($urandom_range(hi + 1, 4095)), 0);
          else
            send_noisy(0, 0);
        end else begin
          repeat (SAMPLES_PER_READING) send_sample(ADC_BITS'($urandom()));
        end
      end
      settle();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_MAP_OFFSET;
    cfg_data      <= '0;
    fail_count    = 0;
    steady        = 1'b0;
    hold_request  = 0;
    regs          = default_regs();
    group_fill    = 0;
    group_sum     = '0;
    in_fault      = 1'b0;
    ema_acc       = '0;
    ema_primed    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_fault_events();
    test_thresholds();
    test_map_extremes();
    test_smoothing();
    test_backpressure();
    test_random_settings();
    settle();
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/afrc_pkg.sv
rtl/afrc_cfg_regs.sv
rtl/afrc_ctrl.sv
rtl/afrc_dp.sv
rtl/wideband_o2_afr_conditioner_top.sv
tb/tb_top.sv
